// ===== hw/rtl/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// gbn_pkg
// shared types and constants of the go-back-n send window
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int SEQ_W  = 16;
   localparam int TYPE_W = 8;
   localparam int TAG_W  = 16;
   localparam int KIND_W = 3;

   // config register widths and indexes
   localparam int CSR_WS_W   = 5;
   localparam int CSR_IB_W   = 2;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BYTES = 1'd1;

   localparam logic [CSR_WS_W-1:0] WINDOW_SIZE_RST = 5'd4;
   localparam logic [CSR_IB_W-1:0] INDEX_BYTES_RST = 2'd1;

   // input kinds
   localparam logic REQ_NEW_FRAME = 1'b0;

   localparam logic [TYPE_W-1:0] ACK_TYPE = 8'd2;

   // result kinds
   localparam logic [KIND_W-1:0] OUT_RELOAD   = 3'd0;
   localparam logic [KIND_W-1:0] OUT_TX       = 3'd1;
   localparam logic [KIND_W-1:0] OUT_OVERFLOW = 3'd2;
   localparam logic [KIND_W-1:0] OUT_BADTYPE  = 3'd3;
   localparam logic [KIND_W-1:0] OUT_EMPTY    = 3'd4;

   localparam logic [SEQ_W-1:0] MASK_ONE_BYTE = 16'h00ff;
   localparam logic [SEQ_W-1:0] MASK_TWO_BYTE = 16'hffff;

   typedef struct packed {
      logic              kind;
      logic [TYPE_W-1:0] type_code;
      logic [SEQ_W-1:0]  seq_index;
      logic [TAG_W-1:0]  payload_tag;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0] out_kind;
      logic [SEQ_W-1:0]  out_index;
      logic [TAG_W-1:0]  out_tag;
      logic              last;
   } rsp_payload_type;

   // one frame descriptor held by a cell
   typedef struct packed {
      logic [SEQ_W-1:0]  index;
      logic [TYPE_W-1:0] ftype;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_PUSH   = 2'd1,
      CELL_SHIFT  = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

endpackage

// ===== hw/rtl/gbn_ifs.sv =====
// ----------------------------------------------------------------------------
// gbn channel interfaces
// valid/ready channels for request and response transactions
// ----------------------------------------------------------------------------
interface gbn_req_if import gbn_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface gbn_rsp_if import gbn_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gbn_cell.sv =====
// ----------------------------------------------------------------------------
// gbn_cell
// one window slot: holds a frame descriptor, loads, shifts or rotates
// ----------------------------------------------------------------------------
module gbn_cell import gbn_pkg::*; #(
   parameter int POS   = 0,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  cell_op_type      op,
   input  logic [CNT_W-1:0] occ,
   input  entry_type        new_entry,
   input  entry_type        next_entry,
   input  entry_type        front_entry,
   output entry_type        entry
);

   localparam logic [CNT_W-1:0] MY_POS    = CNT_W'(POS);
   localparam logic [CNT_W-1:0] MY_POS_P1 = CNT_W'(POS + 1);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (op)
         CELL_PUSH: begin
            if (occ == MY_POS) entry_in = new_entry;
         end
         CELL_SHIFT: begin
            entry_in = next_entry;
         end
         CELL_ROTATE: begin
            // tail of the occupied row takes the front entry
            if (MY_POS_P1 < occ) entry_in = next_entry;
            else if (MY_POS_P1 == occ) entry_in = front_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/gbn_window.sv =====
// ----------------------------------------------------------------------------
// gbn_window
// row of window cells, front of the queue at cell zero
// ----------------------------------------------------------------------------
module gbn_window import gbn_pkg::*; #(
   parameter int WINDOW_MAX = 16,
   parameter int CNT_W      = 5
) (
   input  logic             clock,
   input  cell_op_type      op,
   input  logic [CNT_W-1:0] occ,
   input  entry_type        new_entry,
   output entry_type        front_entry
);

   entry_type cells [WINDOW_MAX];

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      entry_type next_entry;
      if (i == WINDOW_MAX - 1) begin : g_end
         // last cell holds on shift
         assign next_entry = cells[i];
      end else begin : g_mid
         assign next_entry = cells[i + 1];
      end

      gbn_cell #(
         .POS   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .occ         (occ),
         .new_entry   (new_entry),
         .next_entry  (next_entry),
         .front_entry (cells[0]),
         .entry       (cells[i])
      );
   end

   assign front_entry = cells[0];

endmodule

// ===== hw/rtl/go_back_n_send_window_top.sv =====
// ----------------------------------------------------------------------------
// go_back_n_send_window_top
// go-back-n sender window built on a row of descriptor cells
// ----------------------------------------------------------------------------
// The window is a row of WINDOW_MAX cells, front frame in cell zero. A new
// frame that leaves the window short of full, an overflow, an empty-window or
// a bad-type control transaction is decided in the idle state and its single
// result goes straight to the output register. An in-range ack also sends its
// result straight there, then pops the acked frames (the row shifts down by
// one cell a cycle). A transmit pass (window filled, ack out of range, or
// timeout) walks every occupied entry while the row rotates by one cell a
// cycle past cell zero, holding while the result side stalls, then hands out
// the final frame. Every frame of a pass is tested against the index last
// handed on when the pass began. Transmitted frames are held back one step
// so the final one can be marked with last. A new request transaction is
// taken only when the sequencer is idle and the output register is free or
// being drained.
// ----------------------------------------------------------------------------
module go_back_n_send_window_top import gbn_pkg::*; #(
   parameter int WINDOW_MAX = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   gbn_req_if.sink               req_chan,
   gbn_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // occupancy and counters must hold WINDOW_MAX and the 5-bit window size
   localparam int OCC_W = $clog2(WINDOW_MAX + 1);
   localparam int CNT_W = (OCC_W > CSR_WS_W) ? OCC_W : CSR_WS_W;
   localparam logic [CNT_W-1:0] WMAX_C = CNT_W'(WINDOW_MAX);
   localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_POP   = 4'b0010,
      S_TX    = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [SEQ_W-1:0] index;
      logic [TAG_W-1:0] tag;
   } pend_type;

   // config registers
   logic [CSR_WS_W-1:0] window_size_ff;
   logic [CSR_IB_W-1:0] index_bytes_ff;

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SEQ_W-1:0]  last_sent_ff, last_sent_in;
   logic [SEQ_W-1:0]  base_ff, base_in;
   logic              pend_valid_ff, pend_valid_in;
   pend_type          pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   // cell row control
   cell_op_type       cell_op;
   entry_type         new_entry;
   entry_type         front;

   // derived values
   logic [CNT_W-1:0]  ws_ext;
   logic [CNT_W-1:0]  w_eff;
   logic [SEQ_W-1:0]  w_seq;
   logic [SEQ_W-1:0]  mask;
   logic              out_free;
   logic              accept;
   logic [SEQ_W-1:0]  ack_dist;
   logic [CNT_W-1:0]  ack_cnt;
   logic [SEQ_W-1:0]  tx_dist;
   logic              tx_hit;
   logic              tx_stall;

   // effective window: zero means one, saturate at the cell count
   assign ws_ext = CNT_W'(window_size_ff);
   always_comb begin
      if (ws_ext == '0) w_eff = ONE_C;
      else if (ws_ext > WMAX_C) w_eff = WMAX_C;
      else w_eff = ws_ext;
   end
   assign w_seq = SEQ_W'(w_eff);
   assign mask  = (index_bytes_ff >= 2'd2) ? MASK_TWO_BYTE : MASK_ONE_BYTE;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign new_entry.index = req_chan.data.seq_index;
   assign new_entry.ftype = req_chan.data.type_code;
   assign new_entry.tag   = req_chan.data.payload_tag;

   // ack distance from the front frame
   assign ack_dist = (req_chan.data.seq_index - front.index) & mask;
   assign ack_cnt  = CNT_W'(ack_dist) + ONE_C;

   // transmit window test for the entry passing cell zero, against the
   // index last handed on at the start of the pass
   assign tx_dist  = (front.index - base_ff) & mask;
   assign tx_hit   = (tx_dist != '0) && (tx_dist <= w_seq);
   assign tx_stall = tx_hit && pend_valid_ff && !out_free;

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      last_sent_in  = last_sent_ff;
      base_in       = base_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      cell_op       = CELL_HOLD;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // default echo of the transaction, kind set below
               rsp_data_in.out_index = req_chan.data.seq_index;
               rsp_data_in.out_tag   = req_chan.data.payload_tag;
               rsp_data_in.last      = 1'b1;
               rsp_data_in.out_kind  = OUT_RELOAD;
               if (req_chan.data.kind == REQ_NEW_FRAME) begin
                  if (occ_ff >= w_eff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.out_kind = OUT_OVERFLOW;
                  end else begin
                     cell_op = CELL_PUSH;
                     occ_in  = occ_ff + ONE_C;
                     if (occ_in < w_eff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        // window filled: walk every entry
                        cnt_in   = occ_in;
                        state_in = S_TX;
                     end
                  end
               end else if (occ_ff == '0) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.out_kind = OUT_EMPTY;
               end else if (req_chan.data.type_code == ACK_TYPE) begin
                  if (ack_dist < w_seq) begin
                     rsp_valid_in = 1'b1;
                     cnt_in       = (ack_cnt > occ_ff) ? occ_ff : ack_cnt;
                     state_in     = S_POP;
                  end else begin
                     cnt_in   = occ_ff;
                     state_in = S_TX;
                  end
               end else if (req_chan.data.type_code == front.ftype) begin
                  // timeout: rewind to just before the front frame
                  last_sent_in = (front.index - SEQ_W'(1)) & mask;
                  cnt_in       = occ_ff;
                  state_in     = S_TX;
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.out_kind = OUT_BADTYPE;
               end
            end
            // reference index of a pass that may start here
            base_in = last_sent_in;
         end
         S_POP: begin
            cell_op = CELL_SHIFT;
            occ_in  = occ_ff - ONE_C;
            cnt_in  = cnt_ff - ONE_C;
            if (cnt_ff == ONE_C) state_in = S_IDLE;
         end
         S_TX: begin
            if (!tx_stall) begin
               cell_op      = CELL_ROTATE;
               last_sent_in = front.index;
               cnt_in       = cnt_ff - ONE_C;
               if (tx_hit) begin
                  // release the held frame, hold the new one
                  if (pend_valid_ff) begin
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.out_kind  = OUT_TX;
                     rsp_data_in.out_index = pend_ff.index;
                     rsp_data_in.out_tag   = pend_ff.tag;
                     rsp_data_in.last      = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_in.index = front.index;
                  pend_in.tag   = front.tag;
               end
               if (cnt_ff == ONE_C) state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_kind  = OUT_TX;
               rsp_data_in.out_index = pend_ff.index;
               rsp_data_in.out_tag   = pend_ff.tag;
               rsp_data_in.last      = 1'b1;
               pend_valid_in         = 1'b0;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RST;
         index_bytes_ff <= INDEX_BYTES_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[CSR_WS_W-1:0];
            CSR_INDEX_BYTES: index_bytes_ff <= csr_wdata[CSR_IB_W-1:0];
            default: begin
               window_size_ff <= window_size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         cnt_ff        <= '0;
         last_sent_ff  <= '0;
         base_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         cnt_ff        <= cnt_in;
         last_sent_ff  <= last_sent_in;
         base_ff       <= base_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   gbn_window #(
      .WINDOW_MAX (WINDOW_MAX),
      .CNT_W      (CNT_W)
   ) u_window (
      .clock       (clock),
      .op          (cell_op),
      .occ         (occ_ff),
      .new_entry   (new_entry),
      .front_entry (front)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= WMAX_C)
      else $error("occupancy beyond cell count");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (occ_ff != '0) && (cnt_ff != '0))
      else $error("pop on empty window");

   a_tx_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TX) |-> (cnt_ff != '0) && (cnt_ff <= occ_ff))
      else $error("transmit walk count out of range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TX && tx_stall) |=> $stable(cnt_ff) && $stable(last_sent_ff))
      else $error("transmit walk advanced while stalled");
`endif

endmodule

// ===== bench/tb_go_back_n_send_window_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_go_back_n_send_window_top
// self-checking bench for the go-back-n send window
// ----------------------------------------------------------------------------
// A short table of directed transactions covers the empty, full, overflow,
// bad-type, timeout and wraparound cases at the reset settings. Then several
// window settings, extremes among them, each get a run of random traffic
// shaped like real sender traffic: in-order frames, acks into the window,
// timeouts and some noise. A behavioral window model predicts the results
// that the table does not type, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_go_back_n_send_window_top;
   import gbn_pkg::*;

   localparam int WINDOW_DEPTH  = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
   localparam int NUM_DIRECTED  = 22;
   localparam int NUM_PHASES    = 8;

   localparam logic REQ_CONTROL = ~REQ_NEW_FRAME;

   typedef enum logic [1:0] {
      IDLE_NONE     = 2'd0,
      IDLE_SENDER   = 2'd1,
      IDLE_RECEIVER = 2'd2,
      IDLE_BOTH     = 2'd3
   } idle_mode_type;

   // one row of the directed table; out_kind only counts when typed is set
   typedef struct packed {
      logic              kind;
      logic [TYPE_W-1:0] ftype;
      logic [SEQ_W-1:0]  seq;
      logic [TAG_W-1:0]  tag;
      logic              typed;
      logic [KIND_W-1:0] out_kind;
   } directed_row_type;

   // one setting of the window and the traffic run under it
   typedef struct packed {
      logic [CSR_WS_W-1:0] window;
      logic [CSR_IB_W-1:0] ibytes;
      idle_mode_type       idle;
      logic [7:0]          items;
      logic                hold;
      logic                pick_cfg;
   } phase_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gbn_req_if req_chan ();
   gbn_rsp_if rsp_chan ();

   go_back_n_send_window_top #(
      .WINDOW_MAX (WINDOW_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // directed transactions at window 4, one-byte index
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // control transactions on an empty window
      '{REQ_CONTROL,   ACK_TYPE, 16'h0000, 16'h0000, 1'b1, OUT_EMPTY},
      '{REQ_CONTROL,   8'hff,    16'hffff, 16'hffff, 1'b1, OUT_EMPTY},
      // fill the window, the fourth frame sends all four
      '{REQ_NEW_FRAME, 8'd5,     16'h0001, 16'h1111, 1'b1, OUT_RELOAD},
      '{REQ_NEW_FRAME, 8'd5,     16'h0002, 16'h2222, 1'b1, OUT_RELOAD},
      '{REQ_NEW_FRAME, 8'd5,     16'h0003, 16'h3333, 1'b1, OUT_RELOAD},
      '{REQ_NEW_FRAME, 8'd5,     16'h0004, 16'h4444, 1'b0, OUT_TX},
      // frame on a full window, then a control type that matches nothing
      '{REQ_NEW_FRAME, 8'hff,    16'hffff, 16'hffff, 1'b1, OUT_OVERFLOW},
      '{REQ_CONTROL,   8'd7,     16'h0003, 16'h0000, 1'b1, OUT_BADTYPE},
      // timeout resends the window, far ack sends nothing new
      '{REQ_CONTROL,   8'd5,     16'h0000, 16'habcd, 1'b0, OUT_TX},
      '{REQ_CONTROL,   ACK_TYPE, 16'h0080, 16'h0000, 1'b0, OUT_TX},
      // acks in range; upper index bits are ignored at one byte
      '{REQ_CONTROL,   ACK_TYPE, 16'h0002, 16'h5555, 1'b1, OUT_RELOAD},
      '{REQ_CONTROL,   ACK_TYPE, 16'h1004, 16'h6666, 1'b1, OUT_RELOAD},
      // window that wraps through index zero
      '{REQ_NEW_FRAME, 8'd0,     16'h00fe, 16'h0000, 1'b1, OUT_RELOAD},
      '{REQ_NEW_FRAME, 8'd0,     16'h00ff, 16'h0001, 1'b1, OUT_RELOAD},
      '{REQ_NEW_FRAME, 8'd0,     16'h0000, 16'h8000, 1'b1, OUT_RELOAD},
      '{REQ_NEW_FRAME, 8'd0,     16'h0001, 16'hfffe, 1'b0, OUT_TX},
      '{REQ_CONTROL,   ACK_TYPE, 16'h0002, 16'h0000, 1'b0, OUT_TX},
      '{REQ_CONTROL,   8'd0,     16'h0000, 16'h0000, 1'b0, OUT_TX},
      '{REQ_CONTROL,   ACK_TYPE, 16'h0001, 16'h7777, 1'b1, OUT_RELOAD},
      // ack reaching past the last frame pops only what is there
      '{REQ_NEW_FRAME, 8'h80,    16'h0010, 16'h0f0f, 1'b1, OUT_RELOAD},
      '{REQ_CONTROL,   ACK_TYPE, 16'h0012, 16'h0000, 1'b1, OUT_RELOAD},
      '{REQ_CONTROL,   8'h80,    16'h0010, 16'h0000, 1'b1, OUT_EMPTY}
   };

   // window settings: minimum, maximum, zero and out-of-range values
   phase_type phase_plan [NUM_PHASES] = '{
      '{5'd1,  2'd1, IDLE_NONE,     8'd40, 1'b0, 1'b0},
      '{5'd16, 2'd2, IDLE_SENDER,   8'd60, 1'b1, 1'b0},
      '{5'd0,  2'd0, IDLE_RECEIVER, 8'd40, 1'b0, 1'b0},
      '{5'd31, 2'd3, IDLE_BOTH,     8'd60, 1'b0, 1'b0},
      '{5'd8,  2'd2, IDLE_NONE,     8'd50, 1'b0, 1'b0},
      '{5'd2,  2'd1, IDLE_SENDER,   8'd45, 1'b0, 1'b0},
      '{5'd17, 2'd1, IDLE_RECEIVER, 8'd50, 1'b1, 1'b0},
      '{5'd4,  2'd1, IDLE_BOTH,     8'd60, 1'b0, 1'b1}
   };

   // window model state
   logic [SEQ_W-1:0]    win_index [WINDOW_DEPTH];
   logic [TYPE_W-1:0]   win_type  [WINDOW_DEPTH];
   logic [TAG_W-1:0]    win_tag   [WINDOW_DEPTH];
   int unsigned         win_head;
   int unsigned         win_count;
   logic [SEQ_W-1:0]    last_sent;
   logic [CSR_WS_W-1:0] cfg_window;
   logic [CSR_IB_W-1:0] cfg_ibytes;

   rsp_payload_type due_results [$];      // results still owed by the block
   idle_mode_type   idle_mode;
   logic [SEQ_W-1:0] next_seq;            // next in-order frame index
   int unsigned     rsp_hold_req;         // bumped to start a receiver hold-off
   int unsigned     frames_offered;
   int unsigned     results_checked;
   int unsigned     mismatch_count;

   // ------------------------------------------------------------------------
   // window model
   // ------------------------------------------------------------------------
   function automatic int unsigned window_limit();
      int unsigned w;
      w = cfg_window;
      if (w == 0) w = 1;
      if (w > WINDOW_DEPTH) w = WINDOW_DEPTH;
      return w;
   endfunction

   function automatic logic [SEQ_W-1:0] index_mask();
      return (cfg_ibytes >= 2) ? MASK_TWO_BYTE : MASK_ONE_BYTE;
   endfunction

   function automatic rsp_payload_type echo_of(input logic [KIND_W-1:0] k,
                                                input req_payload_type t);
      rsp_payload_type r;
      r.out_kind  = k;
      r.out_index = t.seq_index;
      r.out_tag   = t.payload_tag;
      r.last      = 1'b1;
      return r;
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         win_index[i] = '0;
         win_type[i]  = '0;
         win_tag[i]   = '0;
      end
      win_head   = 0;
      win_count  = 0;
      last_sent  = '0;
      cfg_window = WINDOW_SIZE_RST;
      cfg_ibytes = INDEX_BYTES_RST;
   endfunction

   // send every entry within w past the index last handed on; the last one
   // sent carries the last flag, so each frame is held back one step
   function automatic void replay_window();
      rsp_payload_type  held;
      bit               have_held;
      logic [SEQ_W-1:0] base;
      logic [SEQ_W-1:0] gap;
      int unsigned      w;
      int unsigned      s;
      have_held = 1'b0;
      held      = '0;
      base      = last_sent;
      w         = window_limit();
      for (int unsigned i = 0; i < win_count; i++) begin
         s   = (win_head + i) % WINDOW_DEPTH;
         gap = 16'(win_index[s] - base) & index_mask();
         if (gap >= 1 && gap <= w) begin
            if (have_held) due_results.push_back(held);
            held.out_kind  = OUT_TX;
            held.out_index = win_index[s];
            held.out_tag   = win_tag[s];
            held.last      = 1'b0;
            have_held      = 1'b1;
         end
         last_sent = win_index[s];
      end
      if (have_held) begin
         held.last = 1'b1;
         due_results.push_back(held);
      end
   endfunction

   function automatic void advance_window(input req_payload_type t);
      int unsigned      w;
      int unsigned      cnt;
      int unsigned      s;
      logic [SEQ_W-1:0] m;
      logic [SEQ_W-1:0] front;
      logic [SEQ_W-1:0] gap;
      w = window_limit();
      m = index_mask();
      if (t.kind == REQ_NEW_FRAME) begin
         if (win_count >= w) begin
            due_results.push_back(echo_of(OUT_OVERFLOW, t));
         end else begin
            s            = (win_head + win_count) % WINDOW_DEPTH;
            win_index[s] = t.seq_index;
            win_type[s]  = t.type_code;
            win_tag[s]   = t.payload_tag;
            win_count++;
            if (win_count < w) due_results.push_back(echo_of(OUT_RELOAD, t));
            else replay_window();
         end
      end else if (win_count == 0) begin
         due_results.push_back(echo_of(OUT_EMPTY, t));
      end else begin
         front = win_index[win_head];
         if (t.type_code == ACK_TYPE) begin
            gap = 16'(t.seq_index - front) & m;
            if (gap < w) begin
               cnt = gap + 1;
               if (cnt > win_count) cnt = win_count;
               win_head  = (win_head + cnt) % WINDOW_DEPTH;
               win_count = win_count - cnt;
               due_results.push_back(echo_of(OUT_RELOAD, t));
            end else begin
               replay_window();
            end
         end else if (t.type_code == win_type[win_head]) begin
            // timeout: rewind to just before the front frame
            last_sent = 16'(front - 16'd1) & m;
            replay_window();
         end else begin
            due_results.push_back(echo_of(OUT_BADTYPE, t));
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // random traffic: mostly in-order frames and acks into the window
   // ------------------------------------------------------------------------
   function automatic req_payload_type pick_frame();
      req_payload_type  t;
      logic [31:0]      rnd;
      logic [SEQ_W-1:0] m;
      logic [SEQ_W-1:0] hi;
      logic [SEQ_W-1:0] front;
      int unsigned      w;
      int unsigned      roll;
      w     = window_limit();
      m     = index_mask();
      roll  = $urandom_range(99);
      front = win_index[win_head];
      rnd   = $urandom();
      hi    = rnd[15:0] & ~m;             // bits above the index width
      rnd   = $urandom();
      t.payload_tag = rnd[15:0];
      t.seq_index   = rnd[31:16];
      rnd   = $urandom();
      t.type_code   = rnd[7:0];
      t.kind        = rnd[8];
      // plain noise
      if (roll < 8) return t;
      if (win_count < w && (roll < 70 || (win_count == 0 && roll < 92))) begin
         t.kind      = REQ_NEW_FRAME;
         if (!rnd[9]) t.type_code = 8'($urandom_range(3, 9));
         t.seq_index = (next_seq & m) | hi;
         next_seq    = next_seq + 16'd1;
         return t;
      end
      t.kind = REQ_CONTROL;
      if (win_count == 0) return t;
      roll = $urandom_range(99);
      if (roll < 45) begin
         // ack somewhere inside the window
         t.type_code  = ACK_TYPE;
         t.seq_index  = (16'(front + 16'($urandom_range(0, w - 1))) & m) | hi;
      end else if (roll < 60) begin
         t.type_code = ACK_TYPE;
      end else if (roll < 80) begin
         t.type_code = win_type[win_head];
      end else if (roll >= 92) begin
         // frame while the window may be full
         t.kind      = REQ_NEW_FRAME;
         t.seq_index = (next_seq & m) | hi;
         next_seq    = next_seq + 16'd1;
      end
      return t;
   endfunction

   function automatic bit sender_idles();
      return (idle_mode == IDLE_SENDER && $urandom_range(99) < 55) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 19);
   endfunction

   function automatic bit receiver_stalls();
      return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 55) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 19);
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name,
                                         input logic [SEQ_W-1:0] want,
                                         input logic [SEQ_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_result(input rsp_payload_type got);
      rsp_payload_type want;
      results_checked++;
      if (due_results.size() == 0) begin
         $display("%0t: unexpected result, expected none got kind %h index %h tag %h last %b",
                  $time, got.out_kind, got.out_index, got.out_tag, got.last);
         mismatch_count++;
      end else begin
         want = due_results.pop_front();
         compare_field("out_kind", 16'(want.out_kind), 16'(got.out_kind));
         compare_field("out_index", want.out_index, got.out_index);
         compare_field("out_tag", want.out_tag, got.out_tag);
         compare_field("last", 16'(want.last), 16'(got.last));
      end
   endfunction

   // ------------------------------------------------------------------------
   // sender-side helpers
   // ------------------------------------------------------------------------
   // offer one request transaction; valid stays high after acceptance so a
   // back-to-back transaction never toggles it within one step
   task automatic offer_frame(input req_payload_type frame);
      while (sender_idles()) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= frame;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      frames_offered++;
   endtask

   // stop offering and wait for every owed result
   task automatic drain_window();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   // both registers in back-to-back cycles, write enable held high across them
   task automatic write_window_config(input logic [CSR_WS_W-1:0] ws,
                                      input logic [CSR_IB_W-1:0] ib);
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= CSR_DATA_W'(ws);
      @(posedge clock);
      csr_index <= CSR_INDEX_BYTES;
      csr_wdata <= CSR_DATA_W'(ib);
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_window = ws;
      cfg_ibytes = ib;
   endtask

   // ------------------------------------------------------------------------
   // clock and run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous bound: far above the slowest legal run
   initial begin
      #(5_000_000);
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // result side: random stalls, long hold-offs on request, and checking
   // ------------------------------------------------------------------------
   initial begin : result_side
      int unsigned hold_left;
      int unsigned hold_taken;
      hold_left      = 0;
      hold_taken     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         // values seen here are the ones the block presented at this edge
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            check_result(rsp_chan.data);
         if (hold_taken != rsp_hold_req) begin
            hold_taken = rsp_hold_req;
            hold_left  = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !receiver_stalls();
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus: reset, directed table, then one random run per window setting
   // ------------------------------------------------------------------------
   initial begin : request_side
      req_payload_type     frame;
      int unsigned         queued;
      logic [CSR_WS_W-1:0] ws;
      logic [CSR_IB_W-1:0] ib;
      // every input known from time zero
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.data   = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_WINDOW_SIZE;
      csr_wdata       = '0;
      idle_mode       = IDLE_NONE;
      rsp_hold_req    = 0;
      frames_offered  = 0;
      results_checked = 0;
      mismatch_count  = 0;
      next_seq        = '0;
      clear_window();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset settings
      foreach (directed_rows[k]) begin
         frame.kind        = directed_rows[k].kind;
         frame.type_code   = directed_rows[k].ftype;
         frame.seq_index   = directed_rows[k].seq;
         frame.payload_tag = directed_rows[k].tag;
         offer_frame(frame);
         queued = due_results.size();
         advance_window(frame);
         // rows with a typed answer take it instead of the model's
         if (directed_rows[k].typed) begin
            while (due_results.size() > queued) void'(due_results.pop_back());
            due_results.push_back(echo_of(directed_rows[k].out_kind, frame));
         end
      end

      foreach (phase_plan[p]) begin
         // idle block before a register write; a pass may be producing
         // nothing, so give it its full latency too
         drain_window();
         repeat (SETTLE_CYCLES) @(posedge clock);
         ws = phase_plan[p].window;
         ib = phase_plan[p].ibytes;
         if (phase_plan[p].pick_cfg) begin
            ws = 5'($urandom_range(31));
            ib = 2'($urandom_range(3));
         end
         write_window_config(ws, ib);
         idle_mode = phase_plan[p].idle;
         next_seq  = 16'($urandom());
         // long receiver hold-off while frames keep coming
         if (phase_plan[p].hold) rsp_hold_req++;
         for (int k = 0; k < phase_plan[p].items; k++) begin
            // once per setting, pause until the block owes nothing
            if (k == phase_plan[p].items / 2) drain_window();
            frame = pick_frame();
            offer_frame(frame);
            advance_window(frame);
         end
      end

      drain_window();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d request transactions over %0d window settings plus a directed table",
               frames_offered, NUM_PHASES);
      $display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
